@@ hdl/crlf_pkg.sv @@
// ----------------------------------------------------------------------------
// crlf_pkg
// Shared constants, codes and types of the CR LF frame receiver.
// ----------------------------------------------------------------------------
package crlf_pkg;

	localparam int BUFFER_LENGTH = 64;
	localparam int CNT_W         = $clog2(BUFFER_LENGTH);
	localparam int HEAD_DEPTH    = 5;
	localparam int HEAD_IDX_W    = $clog2(HEAD_DEPTH);
	localparam int LEN_W         = 6;
	localparam int VALUE_W       = 16;

	localparam logic [7:0] CR_BYTE     = 8'h0D;
	localparam logic [7:0] LF_BYTE     = 8'h0A;
	localparam logic [7:0] HEADER_BYTE = 8'hFF;
	localparam logic [7:0] NEG_MARK    = 8'h01;
	localparam logic [6:0] FRAC_SCALE  = 7'd100;

	typedef enum logic [1:0] {
		ST_VALUE   = 2'd0,
		ST_BAD_LEN = 2'd1,
		ST_BAD_HDR = 2'd2
	} frame_status_t;

	typedef logic [7:0] head_bytes_t [HEAD_DEPTH];

	typedef struct packed {
		frame_status_t            status;
		logic [7:0]               command;
		logic signed [VALUE_W-1:0] value;
		logic [LEN_W-1:0]         length;
	} frame_result_t;

endpackage

@@ hdl/crlf_dec.sv @@
// ----------------------------------------------------------------------------
// crlf_dec
// Decodes a completed frame: header check, length check, signed value.
// ----------------------------------------------------------------------------
module crlf_dec (
	input  crlf_pkg::head_bytes_t            head,
	input  logic [crlf_pkg::CNT_W-1:0]       count,
	output crlf_pkg::frame_result_t          result
);

	logic [14:0]                                 int_part;
	logic [crlf_pkg::VALUE_W-1:0]                mag;

	assign int_part  = 15'(head[3]) * 15'(crlf_pkg::FRAC_SCALE);
	assign mag       = {1'b0, int_part} + {8'd0, head[4]};

	always_comb begin
		result.command = head[1];
		result.length  = crlf_pkg::LEN_W'(count);
		result.value   = '0;
		if (head[0] != crlf_pkg::HEADER_BYTE) begin
			result.status = crlf_pkg::ST_BAD_HDR;
		end else if (count != crlf_pkg::CNT_W'(crlf_pkg::HEAD_DEPTH)) begin
			result.status = crlf_pkg::ST_BAD_LEN;
		end else begin
			result.status = crlf_pkg::ST_VALUE;
			if (head[2] == crlf_pkg::NEG_MARK) begin
				result.value = -$signed(mag);
			end else begin
				result.value = $signed(mag);
			end
		end
	end

endmodule

@@ hdl/crlf_frame_receiver_decoder_core.sv @@
// ----------------------------------------------------------------------------
// crlf_frame_receiver_decoder_core
// Assembles CR LF terminated frames from received bytes and decodes them.
// ----------------------------------------------------------------------------
// Input channel: in_valid, in_stall, rx_byte. One received byte per word.
// Output channel: out_valid, out_stall, frame_status, command_code,
// value_hundredths, payload_length. One word per completed frame.
// A byte is taken into an input register and applied to the frame state
// when that register advances, which also loads a completed frame into the
// output register behind the LF word. Throughput is one byte per cycle
// unless out_stall holds a pending result; the input register, frame state
// and output register each update at most once per cycle.
// Bytes other than the LF that closes a frame produce no output word.
// A CR followed by anything but LF drops the frame; a full buffer restarts
// the frame without output.
// Reset clears the count, the CR flag, the first five stored bytes and
// both valid flags.
// While out_stall holds a pending result, the input register still fills,
// and in_stall rises only when that register also waits.
// ----------------------------------------------------------------------------
module crlf_frame_receiver_decoder_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          rx_byte,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          frame_status,
	output logic [7:0]                          command_code,
	output logic signed [crlf_pkg::VALUE_W-1:0] value_hundredths,
	output logic [crlf_pkg::LEN_W-1:0]          payload_length
);

	logic                          valid_s1;
	logic [7:0]                    byte_s1;
	logic                          adv_s1;
	logic                          fire;
	crlf_pkg::head_bytes_t         head_q;
	logic [crlf_pkg::CNT_W-1:0]    count_q;
	logic                          cr_q;
	logic                          out_valid_q;
	crlf_pkg::frame_result_t       dec_result;
	crlf_pkg::frame_result_t       result_q;

	assign adv_s1   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign fire     = cr_q && (byte_s1 == crlf_pkg::LF_BYTE);

	crlf_dec u_dec (
		.head   (head_q),
		.count  (count_q),
		.result (dec_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cr_q    <= 1'b0;
			for (int i = 0; i < crlf_pkg::HEAD_DEPTH; i++) begin
				head_q[i] <= '0;
			end
		end else if (adv_s1) begin
			if (!cr_q) begin
				if (byte_s1 == crlf_pkg::CR_BYTE) begin
					cr_q <= 1'b1;
				end else begin
					if (count_q < crlf_pkg::CNT_W'(crlf_pkg::HEAD_DEPTH)) begin
						head_q[count_q[crlf_pkg::HEAD_IDX_W-1:0]] <= byte_s1;
					end
					if (count_q == crlf_pkg::CNT_W'(crlf_pkg::BUFFER_LENGTH - 1)) begin
						count_q <= '0;
					end else begin
						count_q <= count_q + 1'b1;
					end
				end
			end else begin
				count_q <= '0;
				cr_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= fire;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && fire) begin
			result_q <= dec_result;
		end
	end

	assign out_valid        = out_valid_q;
	assign frame_status     = result_q.status;
	assign command_code     = result_q.command;
	assign value_hundredths = result_q.value;
	assign payload_length   = result_q.length;

endmodule

@@ hdl/crlf_chk.sv @@
// ----------------------------------------------------------------------------
// crlf_chk
// Port-level checks of the CR LF frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module crlf_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  frame_status,
	input logic [7:0]  command_code,
	input logic [15:0] value_hundredths,
	input logic [5:0]  payload_length
);

	a_in_stall_backed: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a stalled output word");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_stall) |=> in_valid)
		else $error("stalled input word dropped");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_status == crlf_pkg::ST_VALUE
			|| frame_status == crlf_pkg::ST_BAD_LEN
			|| frame_status == crlf_pkg::ST_BAD_HDR))
		else $error("undefined frame status");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_status != crlf_pkg::ST_VALUE) |-> (value_hundredths == 16'd0))
		else $error("value set on a frame without a valid value");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(frame_status)
			&& $stable(command_code) && $stable(value_hundredths)
			&& $stable(payload_length)))
		else $error("stalled output word changed");

endmodule

bind crlf_frame_receiver_decoder_core crlf_chk u_crlf_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_stall         (in_stall),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.frame_status     (frame_status),
	.command_code     (command_code),
	.value_hundredths (value_hundredths),
	.payload_length   (payload_length)
);
